/* design/srg_pkg.sv */
// ---------------------------------------------------------------------------
// srg_pkg: shared types and constants of the sorted run generator
// Value width, run length register layout, command and engine state types.
// ---------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

   localparam int VALUE_WIDTH          = 32;
   localparam int RUN_LENGTH_WIDTH     = 5;
   localparam int BUFFER_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [RUN_LENGTH_WIDTH-1:0] RUN_LENGTH_RESET = 5'd10;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_FLUSH  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      value_type    value;
   } cmd_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } engine_state_type;

endpackage

`default_nettype wire

/* design/srg_req_if.sv */
// ---------------------------------------------------------------------------
// srg_req_if: request channel of the sorted run generator
// Valid/ready handshake carrying one value or an end marker.
// ---------------------------------------------------------------------------
`default_nettype none

interface srg_req_if;
   logic               valid;
   logic               ready;
   srg_pkg::value_type value_in;
   logic               end_of_input;

   modport source (output valid, output value_in, output end_of_input, input ready);
   modport sink   (input valid, input value_in, input end_of_input, output ready);
endinterface

`default_nettype wire

/* design/srg_rsp_if.sv */
// ---------------------------------------------------------------------------
// srg_rsp_if: result channel of the sorted run generator
// Valid/ready handshake carrying one sorted value and its end-of-run flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface srg_rsp_if;
   logic               valid;
   logic               ready;
   srg_pkg::value_type sorted_value;
   logic               last_of_run;

   modport source (output valid, output sorted_value, output last_of_run, input ready);
   modport sink   (input valid, input sorted_value, input last_of_run, output ready);
endinterface

`default_nettype wire

/* design/srg_cmd_queue.sv */
// ---------------------------------------------------------------------------
// srg_cmd_queue: front end of the sorted run generator
// Classifies each request as insert or flush and queues it for the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module srg_cmd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire srg_pkg::value_type  in_value,
   input  wire logic                in_end,
   output logic                     cmd_valid,
   output srg_pkg::cmd_type         cmd,
   input  wire logic                cmd_pop
);

   localparam int PtrWidth   = (srg_pkg::QUEUE_DEPTH > 1) ? $clog2(srg_pkg::QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(srg_pkg::QUEUE_DEPTH + 1);

   srg_pkg::cmd_type        entries_ff [srg_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   srg_pkg::cmd_type        new_cmd;
   logic                    push;
   logic                    pop;

   // classify: an end marker becomes a flush, anything else an insert
   always_comb begin
      new_cmd.value = in_value;
      new_cmd.kind  = in_end ? srg_pkg::CMD_FLUSH : srg_pkg::CMD_INSERT;
   end

   assign in_ready  = (count_ff != CountWidth'(srg_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(srg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(srg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

/* design/srg_sort_engine.sv */
// ---------------------------------------------------------------------------
// srg_sort_engine: back end of the sorted run generator
// Sorted insertion row; drains a finished run one value per cycle unless the output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module srg_sort_engine #(
   parameter int BufferDepth = srg_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [srg_pkg::RUN_LENGTH_WIDTH-1:0]  run_length,
   input  wire logic                                  cmd_valid,
   input  wire srg_pkg::cmd_type                      cmd,
   output logic                                       cmd_pop,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output srg_pkg::value_type                         out_value,
   output logic                                       out_last
);

   localparam int FillWidth = $clog2(BufferDepth + 1);

   srg_pkg::value_type        run_store_ff [BufferDepth];
   srg_pkg::value_type        run_store_in [BufferDepth];
   logic [BufferDepth-1:0]    stays;
   logic [FillWidth-1:0]      fill_ff, fill_in;
   logic [FillWidth-1:0]      eff_len;
   srg_pkg::engine_state_type state_ff, state_in;
   logic                      out_valid_ff, out_valid_in;
   srg_pkg::value_type        out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_free;
   logic                      run_full;
   logic                      do_insert;
   logic                      do_shift;

   // zero counts as one, anything past the buffer saturates
   always_comb begin
      if (32'(run_length) > 32'(BufferDepth)) begin
         eff_len = FillWidth'(BufferDepth);
      end else if (run_length == '0) begin
         eff_len = FillWidth'(1);
      end else begin
         eff_len = FillWidth'(run_length);
      end
   end

   assign run_full = (fill_ff >= eff_len);
   assign out_free = !out_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (cmd_valid && (fill_ff != '0)
                && ((cmd.kind == srg_pkg::CMD_FLUSH) || run_full)) begin
               state_in = srg_pkg::ST_DRAIN;
            end
         end
         srg_pkg::ST_DRAIN: begin
            if (out_free && (fill_ff == FillWidth'(1))) begin
               state_in = srg_pkg::ST_IDLE;
            end
         end
         default: state_in = srg_pkg::ST_IDLE;
      endcase
   end

   // actions
   always_comb begin
      cmd_pop   = 1'b0;
      do_insert = 1'b0;
      do_shift  = 1'b0;
      unique case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  srg_pkg::CMD_FLUSH: cmd_pop = (fill_ff == '0);
                  srg_pkg::CMD_INSERT: begin
                     do_insert = !run_full;
                     cmd_pop   = !run_full;
                  end
                  default: cmd_pop = 1'b0;
               endcase
            end
         end
         srg_pkg::ST_DRAIN: do_shift = out_free;
         default: do_shift = 1'b0;
      endcase
   end

   // one compare per cell; the row stays ascending
   for (genvar i = 0; i < BufferDepth; i++) begin : g_cell
      srg_pkg::value_type ins_val;
      srg_pkg::value_type shift_val;

      assign stays[i] = (FillWidth'(i) < fill_ff) && (run_store_ff[i] <= cmd.value);

      if (i == 0) begin : g_first
         assign ins_val   = stays[i] ? run_store_ff[i] : cmd.value;
      end else begin : g_rest
         logic from_left;
         assign from_left = stays[i-1];
         assign ins_val   = stays[i] ? run_store_ff[i]
                                     : (from_left ? cmd.value : run_store_ff[i-1]);
      end

      if (i == BufferDepth - 1) begin : g_tail
         assign shift_val = run_store_ff[i];
      end else begin : g_body
         assign shift_val = run_store_ff[i+1];
      end

      assign run_store_in[i] = do_insert ? ins_val : (do_shift ? shift_val : run_store_ff[i]);
   end

   always_comb begin
      fill_in = fill_ff;
      if (do_insert) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_shift) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (do_shift) begin
         out_valid_in = 1'b1;
         out_value_in = run_store_ff[0];
         out_last_in  = (fill_ff == FillWidth'(1));
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srg_pkg::ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_store_ff <= run_store_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

`ifndef SYNTHESIS
   a_drain_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_DRAIN |-> fill_ff != '0)
      else $error("drain with empty buffer");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillWidth'(BufferDepth))
      else $error("fill count beyond buffer depth");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= FillWidth'(2) |-> run_store_ff[0] <= run_store_ff[1])
      else $error("buffer head out of order");

   a_result_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == srg_pkg::ST_DRAIN))
      else $error("result outside of a drain");
`endif

endmodule

`default_nettype wire

/* design/sorted_run_generator.sv */
// ---------------------------------------------------------------------------
// sorted_run_generator: run generation stage of an external merge sort
// Collects signed values into runs and emits each run in ascending order.
// ---------------------------------------------------------------------------
// Requests carry a signed 32-bit value or an end marker. Values collect in a
// buffer that is kept sorted as they arrive; once it holds run_length values
// (0 counts as 1, values above BUFFER_DEPTH saturate), the next value first
// pushes the whole run out in ascending order, last value flagged, and then
// starts the new run. An end marker flushes a partial run, or nothing when
// the buffer is empty. A front queue of two requests takes input while the
// engine drains; each accepted request waits in the queue for the engine.
// The value that closes a run first lets the engine see the full buffer,
// then drains the run with one result per cycle through the shift row
// into the output register (stalling while rsp.ready is low and a result
// is held), and then stores the value. An end marker on a partial run
// takes the same steps but is popped instead of stored. The engine takes
// no new value while it drains; the drain of the sorted row bounds the
// sustained throughput. No clearing pass after reset.
// Write csr_write_data only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_run_generator #(
   parameter int BUFFER_DEPTH = srg_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   srg_req_if.sink                                    req,
   srg_rsp_if.source                                  rsp,
   input  wire logic                                  csr_write_enable,
   input  wire logic [srg_pkg::RUN_LENGTH_WIDTH-1:0]  csr_write_data
);

   // run length register
   logic [srg_pkg::RUN_LENGTH_WIDTH-1:0] run_length_ff, run_length_in;

   // front to back command path
   logic             cmd_valid;
   srg_pkg::cmd_type cmd;
   logic             cmd_pop;

   assign run_length_in = csr_write_enable ? csr_write_data : run_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff <= srg_pkg::RUN_LENGTH_RESET;
      end else begin
         run_length_ff <= run_length_in;
      end
   end

   // front: classify each request and queue it
   srg_cmd_queue u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_value  (req.value_in),
      .in_end    (req.end_of_input),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back: sorted buffer, run drain and output register
   srg_sort_engine #(
      .BufferDepth (BUFFER_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .run_length (run_length_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_value  (rsp.sorted_value),
      .out_last   (rsp.last_of_run)
   );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: regression bench for the sorted run generator
// Sends values and end markers over the request channel and predicts every
// run the block should emit. Each sorted value is checked in order against
// that prediction. Covers directed corner runs, run length extremes and
// random traffic under three sender and receiver idling mixes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one predicted output beat: a sorted value and its end-of-run flag
   typedef struct packed {
      srg_pkg::value_type value;
      logic               last;
   } run_beat_type;

   localparam int                 RUN_DEPTH      = srg_pkg::BUFFER_DEPTH_DEFAULT;
   localparam int                 LEN_WIDTH      = srg_pkg::RUN_LENGTH_WIDTH;
   // after the last result the engine may still be storing a value that
   // sits in the two-deep front queue; this covers it with margin
   localparam int                 SETTLE_CYCLES  = 20;
   localparam int                 DRAIN_LIMIT    = 20000;
   localparam int                 REPORT_CAP     = 40;
   localparam srg_pkg::value_type VALUE_MIN      = 32'sh8000_0000;
   localparam srg_pkg::value_type VALUE_MAX      = 32'sh7fff_ffff;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [LEN_WIDTH-1:0] csr_write_data;

   srg_req_if req_ch ();
   srg_rsp_if rsp_ch ();

   sorted_run_generator #(
      .BUFFER_DEPTH (RUN_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: sorted buffer, fill level and run length
   // ------------------------------------------------------------------
   srg_pkg::value_type          shadow_buf [RUN_DEPTH];
   int                          shadow_fill;
   logic [LEN_WIDTH-1:0]        shadow_run_len;
   run_beat_type                beats_due [$];

   int                 mismatch_count;
   int                 send_idle_pct;
   int                 rsp_stall_pct;
   srg_pkg::value_type last_sent;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP)
         $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   // 0 behaves as 1, anything past the buffer depth saturates
   function automatic int run_limit();
      int len;
      len = int'(shadow_run_len);
      if (len == 0)
         len = 1;
      if (len > RUN_DEPTH)
         len = RUN_DEPTH;
      return len;
   endfunction

   // Queue the whole buffered run (already held in order) as due beats.
   function automatic void release_run();
      run_beat_type beat;
      for (int i = 0; i < shadow_fill; i++) begin
         beat.value = shadow_buf[i];
         beat.last  = (i == shadow_fill - 1);
         beats_due  = {beats_due, beat};
      end
      shadow_fill = 0;
   endfunction

   // Apply one accepted request to the shadow. The buffer is kept sorted
   // on insert, so a run is released straight from it.
   function automatic void sort_into_runs(input srg_pkg::cmd_kind_type kind,
                                          input srg_pkg::value_type v);
      int j;
      if (kind == srg_pkg::CMD_FLUSH) begin
         release_run();
         return;
      end
      // a full buffer, or one left above a newly lowered run length,
      // goes out before the new value lands
      if (shadow_fill >= run_limit())
         release_run();
      if (shadow_fill < RUN_DEPTH) begin
         j = shadow_fill;
         while (j > 0 && shadow_buf[j-1] > v) begin
            shadow_buf[j] = shadow_buf[j-1];
            j--;
         end
         shadow_buf[j] = v;
         shadow_fill++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // valid is left high after acceptance so back-to-back requests never
   // see a low/high pair in the same step; gaps lower it between requests
   task automatic send_request(input srg_pkg::cmd_kind_type kind,
                               input srg_pkg::value_type v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.value_in     <= v;
      req_ch.end_of_input <= kind;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sort_into_runs(kind, v);
      if (kind == srg_pkg::CMD_INSERT)
         last_sent = v;
   endtask

   // stop sending and let every predicted beat come back
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (beats_due.size() != 0);
   endtask

   // register write only with the block quiet
   task automatic set_run_length(input logic [LEN_WIDTH-1:0] len);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_run_len = len;
   endtask

   // value mix: extremes, small clustered values, repeats and full range
   function automatic srg_pkg::value_type pick_value();
      case ($urandom_range(7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return srg_pkg::value_type'(int'($urandom_range(16)) - 8);
         3: return last_sent;
         4: return $urandom_range(1) ? srg_pkg::value_type'(0) : srg_pkg::value_type'(-1);
         default: return srg_pkg::value_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stalls on ready, in-order check of every beat
   // ------------------------------------------------------------------
   initial begin
      run_beat_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (beats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result value=%0d last=%b",
                  rsp_ch.sorted_value, rsp_ch.last_of_run));
            end else begin
               want = beats_due.pop_front();
               if (rsp_ch.sorted_value !== want.value)
                  report_mismatch($sformatf("sorted_value got %0d want %0d",
                     rsp_ch.sorted_value, want.value));
               if (rsp_ch.last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run got %b want %b (value %0d)",
                     rsp_ch.last_of_run, want.last, want.value));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset run length of 10: extremes, equal values, signed order. The
   // eleventh value closes the run, a marker flushes the lone leftover and
   // a second marker finds the buffer empty and must emit nothing.
   task automatic test_reset_length_run();
      send_request(srg_pkg::CMD_INSERT, VALUE_MAX);
      send_request(srg_pkg::CMD_INSERT, VALUE_MIN);
      send_request(srg_pkg::CMD_INSERT, 32'sd0);
      send_request(srg_pkg::CMD_INSERT, -32'sd1);
      send_request(srg_pkg::CMD_INSERT, 32'sd1);
      send_request(srg_pkg::CMD_INSERT, 32'sd7);
      send_request(srg_pkg::CMD_INSERT, 32'sd7);
      send_request(srg_pkg::CMD_INSERT, 32'sh5555_5555);
      send_request(srg_pkg::CMD_INSERT, 32'shaaaa_aaaa);
      send_request(srg_pkg::CMD_INSERT, VALUE_MIN);
      send_request(srg_pkg::CMD_INSERT, 32'sd42);
      send_request(srg_pkg::CMD_FLUSH,  32'shffff_ffff);
      send_request(srg_pkg::CMD_FLUSH,  32'sd0);
   endtask

   // run length 0 acts as 1: each new value pushes out the previous one
   task automatic test_zero_length();
      set_run_length(5'd0);
      send_request(srg_pkg::CMD_INSERT, VALUE_MAX);
      send_request(srg_pkg::CMD_INSERT, VALUE_MIN);
      send_request(srg_pkg::CMD_FLUSH,  VALUE_MAX);
   endtask

   // saturated length, then lowered under the fill level: the next value
   // must push all four buffered values out as one run
   task automatic test_lowered_length();
      set_run_length(5'd31);
      send_request(srg_pkg::CMD_INSERT, 32'sd3);
      send_request(srg_pkg::CMD_INSERT, -32'sd3);
      send_request(srg_pkg::CMD_INSERT, 32'sd3);
      send_request(srg_pkg::CMD_INSERT, 32'sd0);
      set_run_length(5'd2);
      send_request(srg_pkg::CMD_INSERT, 32'sd9);
      send_request(srg_pkg::CMD_FLUSH,  32'sd0);
   endtask

   // mostly values with the odd end marker; now and then the sender holds
   // off until every predicted beat is back
   task automatic test_random_runs(input logic [LEN_WIDTH-1:0] len, input int count);
      set_run_length(len);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(39) == 0)
            hold_until_drained();
         if ($urandom_range(99) < 8)
            send_request(srg_pkg::CMD_FLUSH, srg_pkg::value_type'($urandom));
         else
            send_request(srg_pkg::CMD_INSERT, pick_value());
      end
   endtask

   // one idling mix, three run length settings
   task automatic test_idle_mix(input int send_pct, input int stall_pct,
                                input logic [LEN_WIDTH-1:0] len_a,
                                input logic [LEN_WIDTH-1:0] len_b);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      test_random_runs(len_a, 36);
      test_random_runs(len_b, 36);
      test_random_runs(LEN_WIDTH'($urandom_range(31)), 36);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      shadow_fill      = 0;
      shadow_run_len   = srg_pkg::RUN_LENGTH_RESET;
      mismatch_count   = 0;
      last_sent        = '0;
      send_idle_pct    = 26;
      rsp_stall_pct    = 74;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.value_in     <= '0;
      req_ch.end_of_input <= srg_pkg::CMD_INSERT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length_run();
      test_zero_length();
      test_lowered_length();

      test_idle_mix(26, 74, 5'd1,  5'd16);
      test_idle_mix(74, 26, 5'd31, 5'd0);
      test_idle_mix(0,  0,  5'd10, 5'd5);

      // last partial run out, then wait for the tail with a bound
      send_request(srg_pkg::CMD_FLUSH, '0);
      req_ch.valid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && beats_due.size() != 0; w++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (beats_due.size() != 0) begin
         report_mismatch($sformatf("missing result value=%0d last=%b",
            beats_due[0].value, beats_due[0].last));
         void'(beats_due.pop_front());
      end

      if (mismatch_count == 0)
         $display("sorted_run_generator regression: pass");
      else
         $display("sorted_run_generator regression: fail");
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #400000;
      $display("sorted_run_generator regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/srg_pkg.sv
design/srg_req_if.sv
design/srg_rsp_if.sv
design/srg_cmd_queue.sv
design/srg_sort_engine.sv
design/sorted_run_generator.sv
verif/tb_top.sv
